@@ design/cpu_exu_pkg.sv @@
// Shared types, opcode field codes and flag positions for the 6502 execute unit.
package cpu_exu_pkg;

  // Opcode split aaabbbcc: group codes (cc)
  localparam logic [1:0] CC_CTL = 2'b00;
  localparam logic [1:0] CC_ALU = 2'b01;
  localparam logic [1:0] CC_RMW = 2'b10;

  // ALU group rows (aaa, cc = 01)
  localparam logic [2:0] A_ORA = 3'b000;
  localparam logic [2:0] A_AND = 3'b001;
  localparam logic [2:0] A_EOR = 3'b010;
  localparam logic [2:0] A_ADC = 3'b011;
  localparam logic [2:0] A_LDA = 3'b101;
  localparam logic [2:0] A_CMP = 3'b110;

  // Read-modify-write group rows (aaa, cc = 10)
  localparam logic [2:0] R_ASL = 3'b000;
  localparam logic [2:0] R_ROL = 3'b001;
  localparam logic [2:0] R_LSR = 3'b010;
  localparam logic [2:0] R_ROR = 3'b011;
  localparam logic [2:0] R_LDX = 3'b101;
  localparam logic [2:0] R_DEC = 3'b110;
  localparam logic [2:0] R_INC = 3'b111;

  // Control group rows (aaa, cc = 00)
  localparam logic [2:0] ROW_PHP = 3'b000;
  localparam logic [2:0] ROW_BIT = 3'b001;
  localparam logic [2:0] ROW_PHA = 3'b010;
  localparam logic [2:0] ROW_PLA = 3'b011;
  localparam logic [2:0] ROW_DEY = 3'b100;
  localparam logic [2:0] ROW_LDY = 3'b101;
  localparam logic [2:0] ROW_CPY = 3'b110;
  localparam logic [2:0] ROW_CPX = 3'b111;

  // Addressing columns (bbb)
  localparam logic [2:0] B_IMM  = 3'b000;
  localparam logic [2:0] B_ZP   = 3'b001;
  localparam logic [2:0] B_IMPL = 3'b010;
  localparam logic [2:0] B_ABS  = 3'b011;
  localparam logic [2:0] B_REL  = 3'b100;
  localparam logic [2:0] B_FLAG = 3'b110;

  // Halt opcode
  localparam logic [7:0] OPC_HALT = 8'h02;

  // Flag bit positions in P (NV1BDIZC)
  localparam logic [2:0] FLAG_C = 3'd0;
  localparam logic [2:0] FLAG_Z = 3'd1;
  localparam logic [2:0] FLAG_I = 3'd2;
  localparam logic [2:0] FLAG_D = 3'd3;
  localparam logic [2:0] FLAG_B = 3'd4;
  localparam logic [2:0] FLAG_U = 3'd5;
  localparam logic [2:0] FLAG_V = 3'd6;
  localparam logic [2:0] FLAG_N = 3'd7;

  localparam logic [7:0] FLAGS_RESET = 8'h24;

  typedef enum logic [1:0] {
    OUTCOME_DONE    = 2'd0,
    OUTCOME_ILLEGAL = 2'd1,
    OUTCOME_HALT    = 2'd2
  } outcome_t;

  typedef enum logic [4:0] {
    OP_ILLEGAL,
    OP_HALT,
    OP_NOP,
    OP_ADC,
    OP_LD,
    OP_AND,
    OP_ORA,
    OP_EOR,
    OP_SHIFT,
    OP_INC,
    OP_DEC,
    OP_CMP,
    OP_BIT,
    OP_BRANCH,
    OP_CLR,
    OP_PUSH,
    OP_PLP
  } exu_op_t;

  typedef enum logic [1:0] {
    SEL_A,
    SEL_X,
    SEL_Y,
    SEL_P
  } reg_sel_t;

  // Encoding follows the opcode row bits aaa[1:0]
  typedef enum logic [1:0] {
    SH_ASL = 2'd0,
    SH_ROL = 2'd1,
    SH_LSR = 2'd2,
    SH_ROR = 2'd3
  } shift_t;

  typedef struct packed {
    exu_op_t    op;
    reg_sel_t   sel;        // register source or destination
    logic       use_mem;    // operate on the operand byte, write it back
    shift_t     sh;
    logic [2:0] flag_bit;   // flag tested by a branch or cleared
    logic       flag_want;  // branch taken when the flag equals this
  } dec_t;

  typedef struct packed {
    logic [7:0] kind;
    logic [7:0] operand;
  } in_item_t;

  typedef struct packed {
    logic [7:0] write_data;
    logic       mem_write;
    logic       stack_push;
    logic       branch_taken;
    logic [1:0] outcome;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] flags_out;
  } out_item_t;

endpackage

@@ design/cpu6502_execute_unit_top.sv @@
// Top level of the 6502 execute unit: input register, execute logic, result register.
//
//  channel | direction | handshake           | item
//  op      | in        | op_valid / op_stall | in_item_t  (kind, operand)
//  res     | out       | res_valid/res_stall | out_item_t (write_data .. flags_out)
//
// Each item waits in the input register until the result register is free or taken,
// then moves into it; one item per cycle is sustained while the result is not stalled,
// set by the single 8-bit ALU pass between the two registers and the A/X/Y/P registers.
// Reset clears both valid bits, A, X and Y, and sets P to 0x24.
// A stalled result holds; the input register takes an item while it is empty,
// or while the result register is empty or being taken.
module cpu6502_execute_unit_top
  import cpu_exu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      op_valid,
  output logic      op_stall,
  input  in_item_t  op,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res
);

  logic       in_vld;
  in_item_t   in_q;
  logic       advance;
  logic [7:0] acc;
  logic [7:0] idx_x;
  logic [7:0] idx_y;
  logic [7:0] flags;
  dec_t       dec;
  out_item_t  res_next;

  assign advance  = ~res_valid | ~res_stall;
  assign op_stall = in_vld & ~advance;

  cpu_exu_decode u_decode (
    .kind (in_q.kind),
    .dec  (dec)
  );

  cpu_exu_alu u_alu (
    .dec     (dec),
    .operand (in_q.operand),
    .acc     (acc),
    .idx_x   (idx_x),
    .idx_y   (idx_y),
    .flags   (flags),
    .res     (res_next)
  );

  // Input register: load when the stage is free
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!op_stall) begin
      in_vld <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && !op_stall) begin
      in_q <= op;
    end
  end

  // Result register: advance when empty or taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_vld) begin
      res <= res_next;
    end
  end

  // Architectural registers: commit when the item moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc   <= 8'd0;
      idx_x <= 8'd0;
      idx_y <= 8'd0;
      flags <= FLAGS_RESET;
    end else if (advance && in_vld) begin
      acc   <= res_next.acc_out;
      idx_x <= res_next.x_out;
      idx_y <= res_next.y_out;
      flags <= res_next.flags_out;
    end
  end

endmodule

@@ design/cpu_exu_decode.sv @@
// Opcode decoder: splits the 6502 opcode into an operation and its controls.
module cpu_exu_decode
  import cpu_exu_pkg::*;
(
  input  logic [7:0] kind,
  output dec_t       dec
);

  logic [2:0] aaa;
  logic [2:0] bbb;
  logic [1:0] cc;
  logic       mem_col;   // zp, abs, zp,x or abs,x column
  logic       load_col;  // columns valid for LDX and LDY

  assign aaa      = kind[7:5];
  assign bbb      = kind[4:2];
  assign cc       = kind[1:0];
  assign mem_col  = bbb[0];
  assign load_col = bbb[0] | (bbb == B_IMM);

  // Decode by opcode group, row and column
  always_comb begin
    dec.op        = OP_ILLEGAL;
    dec.sel       = SEL_A;
    dec.use_mem   = 1'b0;
    dec.sh        = shift_t'(aaa[1:0]);
    dec.flag_bit  = FLAG_C;
    dec.flag_want = aaa[0];

    case (cc)
      CC_ALU: begin
        case (aaa)
          A_ORA:   dec.op = OP_ORA;
          A_AND:   dec.op = OP_AND;
          A_EOR:   dec.op = OP_EOR;
          A_ADC:   dec.op = OP_ADC;
          A_LDA:   dec.op = OP_LD;
          A_CMP:   dec.op = OP_CMP;
          default: dec.op = OP_ILLEGAL;
        endcase
      end
      CC_RMW: begin
        case (aaa)
          R_ASL, R_ROL, R_LSR, R_ROR: begin
            if (mem_col) begin
              dec.op      = OP_SHIFT;
              dec.use_mem = 1'b1;
            end else if (bbb == B_IMPL) begin
              dec.op = OP_SHIFT;
            end
          end
          R_LDX: begin
            if (load_col) begin
              dec.op  = OP_LD;
              dec.sel = SEL_X;
            end
          end
          R_DEC: begin
            if (mem_col) begin
              dec.op      = OP_DEC;
              dec.use_mem = 1'b1;
            end else if (bbb == B_IMPL) begin
              dec.op  = OP_DEC;
              dec.sel = SEL_X;
            end
          end
          R_INC: begin
            if (mem_col) begin
              dec.op      = OP_INC;
              dec.use_mem = 1'b1;
            end else if (bbb == B_IMPL) begin
              dec.op = OP_NOP;
            end
          end
          default: dec.op = OP_ILLEGAL;
        endcase
      end
      CC_CTL: begin
        if (bbb == B_REL) begin
          // Branch: row bits pick N, V, C or Z
          dec.op = OP_BRANCH;
          case (aaa[2:1])
            2'b00:   dec.flag_bit = FLAG_N;
            2'b01:   dec.flag_bit = FLAG_V;
            2'b10:   dec.flag_bit = FLAG_C;
            default: dec.flag_bit = FLAG_Z;
          endcase
        end else begin
          case (aaa)
            ROW_PHP: begin
              if (bbb == B_IMPL) begin
                dec.op  = OP_PUSH;
                dec.sel = SEL_P;
              end else if (bbb == B_FLAG) begin
                dec.op       = OP_CLR;
                dec.flag_bit = FLAG_C;
              end
            end
            ROW_BIT: begin
              if (bbb == B_ZP || bbb == B_ABS) begin
                dec.op = OP_BIT;
              end else if (bbb == B_IMPL) begin
                dec.op = OP_PLP;
              end
            end
            ROW_PHA: begin
              if (bbb == B_IMPL) begin
                dec.op = OP_PUSH;
              end else if (bbb == B_FLAG) begin
                dec.op       = OP_CLR;
                dec.flag_bit = FLAG_I;
              end
            end
            ROW_PLA: begin
              if (bbb == B_IMPL) begin
                dec.op = OP_LD;
              end
            end
            ROW_DEY: begin
              if (bbb == B_IMPL) begin
                dec.op  = OP_DEC;
                dec.sel = SEL_Y;
              end
            end
            ROW_LDY: begin
              if (load_col) begin
                dec.op  = OP_LD;
                dec.sel = SEL_Y;
              end else if (bbb == B_FLAG) begin
                dec.op       = OP_CLR;
                dec.flag_bit = FLAG_V;
              end
            end
            ROW_CPY: begin
              if (bbb == B_IMM || bbb == B_ZP || bbb == B_ABS) begin
                dec.op  = OP_CMP;
                dec.sel = SEL_Y;
              end else if (bbb == B_IMPL) begin
                dec.op  = OP_INC;
                dec.sel = SEL_Y;
              end else if (bbb == B_FLAG) begin
                dec.op       = OP_CLR;
                dec.flag_bit = FLAG_D;
              end
            end
            ROW_CPX: begin
              if (bbb == B_IMM || bbb == B_ZP || bbb == B_ABS) begin
                dec.op  = OP_CMP;
                dec.sel = SEL_X;
              end else if (bbb == B_IMPL) begin
                dec.op  = OP_INC;
                dec.sel = SEL_X;
              end
            end
            default: dec.op = OP_ILLEGAL;
          endcase
        end
      end
      default: dec.op = OP_ILLEGAL;
    endcase

    if (kind == OPC_HALT) begin
      dec.op = OP_HALT;
    end
  end

endmodule

@@ design/cpu_exu_alu.sv @@
// Execute stage: 8-bit ALU, shifter and flag update on the register state.
module cpu_exu_alu
  import cpu_exu_pkg::*;
(
  input  dec_t       dec,
  input  logic [7:0] operand,
  input  logic [7:0] acc,
  input  logic [7:0] idx_x,
  input  logic [7:0] idx_y,
  input  logic [7:0] flags,
  output out_item_t  res
);

  logic [7:0] src;       // register or operand being worked on
  logic [8:0] sum;
  logic [8:0] diff;
  logic [7:0] sh_val;
  logic       sh_cout;
  logic [7:0] val;       // result that sets Z and N
  logic       cin;

  assign cin = flags[FLAG_C];

  // Select the register source, or the operand byte when use_mem is set
  always_comb begin
    case (dec.sel)
      SEL_X:   src = idx_x;
      SEL_Y:   src = idx_y;
      SEL_P:   src = flags;
      default: src = acc;
    endcase
    if (dec.use_mem) begin
      src = operand;
    end
  end

  assign sum  = {1'b0, acc} + {1'b0, operand} + {8'd0, cin};
  assign diff = {1'b0, src} - {1'b0, operand};

  // Shift or rotate by one
  always_comb begin
    case (dec.sh)
      SH_ASL:  begin sh_val = {src[6:0], 1'b0}; sh_cout = src[7]; end
      SH_ROL:  begin sh_val = {src[6:0], cin};  sh_cout = src[7]; end
      SH_LSR:  begin sh_val = {1'b0, src[7:1]}; sh_cout = src[0]; end
      default: begin sh_val = {cin, src[7:1]};  sh_cout = src[0]; end
    endcase
  end

  // Apply the operation
  always_comb begin
    res.write_data   = 8'd0;
    res.mem_write    = 1'b0;
    res.stack_push   = 1'b0;
    res.branch_taken = 1'b0;
    res.outcome      = OUTCOME_DONE;
    res.acc_out      = acc;
    res.x_out        = idx_x;
    res.y_out        = idx_y;
    res.flags_out    = flags;
    val              = 8'd0;

    case (dec.op)
      OP_ADC: begin
        val                      = sum[7:0];
        res.acc_out              = val;
        res.flags_out[FLAG_C]    = sum[8];
        res.flags_out[FLAG_V]    = ~(acc[7] ^ operand[7]) & (acc[7] ^ sum[7]);
        res.flags_out[FLAG_Z]    = (val == 8'd0);
        res.flags_out[FLAG_N]    = val[7];
      end
      OP_LD, OP_AND, OP_ORA, OP_EOR: begin
        case (dec.op)
          OP_AND:  val = acc & operand;
          OP_ORA:  val = acc | operand;
          OP_EOR:  val = acc ^ operand;
          default: val = operand;
        endcase
        case (dec.sel)
          SEL_X:   res.x_out   = val;
          SEL_Y:   res.y_out   = val;
          default: res.acc_out = val;
        endcase
        res.flags_out[FLAG_Z] = (val == 8'd0);
        res.flags_out[FLAG_N] = val[7];
      end
      OP_SHIFT, OP_INC, OP_DEC: begin
        case (dec.op)
          OP_INC:  val = src + 8'd1;
          OP_DEC:  val = src - 8'd1;
          default: val = sh_val;
        endcase
        if (dec.op == OP_SHIFT) begin
          res.flags_out[FLAG_C] = sh_cout;
        end
        if (dec.use_mem) begin
          res.write_data = val;
          res.mem_write  = 1'b1;
        end else begin
          case (dec.sel)
            SEL_X:   res.x_out   = val;
            SEL_Y:   res.y_out   = val;
            default: res.acc_out = val;
          endcase
        end
        res.flags_out[FLAG_Z] = (val == 8'd0);
        res.flags_out[FLAG_N] = val[7];
      end
      OP_CMP: begin
        res.flags_out[FLAG_C] = ~diff[8];
        res.flags_out[FLAG_Z] = (diff[7:0] == 8'd0);
        res.flags_out[FLAG_N] = diff[7];
      end
      OP_BIT: begin
        res.flags_out[FLAG_Z] = ((acc & operand) == 8'd0);
        res.flags_out[FLAG_N] = operand[7];
        res.flags_out[FLAG_V] = operand[6];
      end
      OP_BRANCH: begin
        res.branch_taken = (flags[dec.flag_bit] == dec.flag_want);
      end
      OP_CLR: begin
        res.flags_out[dec.flag_bit] = 1'b0;
      end
      OP_PUSH: begin
        res.write_data = src;
        if (dec.sel == SEL_P) begin
          res.write_data[FLAG_B] = 1'b1;
          res.write_data[FLAG_U] = 1'b1;
        end
        res.stack_push = 1'b1;
      end
      OP_PLP: begin
        res.flags_out         = operand;
        res.flags_out[FLAG_B] = 1'b0;
        res.flags_out[FLAG_U] = 1'b1;
      end
      OP_NOP: begin
        res.outcome = OUTCOME_DONE;
      end
      OP_HALT: begin
        res.outcome = OUTCOME_HALT;
      end
      default: begin
        res.outcome = OUTCOME_ILLEGAL;
      end
    endcase
  end

endmodule

@@ tb/cpu6502_execute_unit_top_tb.sv @@
// Self-checking testbench for the 6502 execute unit with an opcode-level predictor.
module cpu6502_execute_unit_top_tb;
  import cpu_exu_pkg::*;

  localparam int RANDOM_ITEMS = 750;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_PRINTED  = 100;

  // Opcodes that the stimulus names or that the control group decodes
  localparam logic [7:0] OPC_BRK      = 8'h00;
  localparam logic [7:0] OPC_JSR      = 8'h20;
  localparam logic [7:0] OPC_LDA_IMM  = 8'hA9;
  localparam logic [7:0] OPC_ADC_IMM  = 8'h69;
  localparam logic [7:0] OPC_CMP_IMM  = 8'hC9;
  localparam logic [7:0] OPC_ASL_A    = 8'h0A;
  localparam logic [7:0] OPC_ROL_A    = 8'h2A;
  localparam logic [7:0] OPC_LSR_A    = 8'h4A;
  localparam logic [7:0] OPC_ROR_ABS  = 8'h6E;
  localparam logic [7:0] OPC_INC_ZP   = 8'hE6;
  localparam logic [7:0] OPC_DEC_ZP   = 8'hC6;
  localparam logic [7:0] OPC_LDX_IMM  = 8'hA2;
  localparam logic [7:0] OPC_DEX      = 8'hCA;
  localparam logic [7:0] OPC_BVS      = 8'h70;
  localparam logic [7:0] OPC_PHP      = 8'h08;
  localparam logic [7:0] OPC_PLP      = 8'h28;
  localparam logic [7:0] OPC_PHA      = 8'h48;
  localparam logic [7:0] OPC_PLA      = 8'h68;
  localparam logic [7:0] OPC_DEY      = 8'h88;
  localparam logic [7:0] OPC_INY      = 8'hC8;
  localparam logic [7:0] OPC_INX      = 8'hE8;
  localparam logic [7:0] OPC_CLC      = 8'h18;
  localparam logic [7:0] OPC_CLI      = 8'h58;
  localparam logic [7:0] OPC_CLV      = 8'hB8;
  localparam logic [7:0] OPC_CLD      = 8'hD8;
  localparam logic [7:0] OPC_BIT_ZP   = 8'h24;
  localparam logic [7:0] OPC_BIT_ABS  = 8'h2C;
  localparam logic [7:0] OPC_LDY_IMM  = 8'hA0;
  localparam logic [7:0] OPC_LDY_ZP   = 8'hA4;
  localparam logic [7:0] OPC_LDY_ABS  = 8'hAC;
  localparam logic [7:0] OPC_LDY_ZPX  = 8'hB4;
  localparam logic [7:0] OPC_LDY_ABSX = 8'hBC;
  localparam logic [7:0] OPC_CPY_IMM  = 8'hC0;
  localparam logic [7:0] OPC_CPY_ZP   = 8'hC4;
  localparam logic [7:0] OPC_CPY_ABS  = 8'hCC;
  localparam logic [7:0] OPC_CPX_IMM  = 8'hE0;
  localparam logic [7:0] OPC_CPX_ZP   = 8'hE4;
  localparam logic [7:0] OPC_CPX_ABS  = 8'hEC;

  typedef struct {
    in_item_t  item;
    out_item_t want;
  } expectation_t;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      op_valid = 1'b0;
  logic      op_stall;
  in_item_t  op = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  out_item_t res;

  // Predicted architectural state
  logic [7:0] p_a;
  logic [7:0] p_x;
  logic [7:0] p_y;
  logic [7:0] p_flags;

  expectation_t pending_results[$];
  stim_row_t    directed_rows[$];
  logic [7:0]   legal_kinds[$];
  int           errors = 0;
  int unsigned  cycle_count = 0;
  int           send_calm = 0;
  int           sink_calm = 0;

  cpu6502_execute_unit_top DUT (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_stall  (op_stall),
    .op        (op),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void reset_model();
    p_a = '0;
    p_x = '0;
    p_y = '0;
    p_flags = FLAGS_RESET;
  endfunction

  function automatic void set_zn(input logic [7:0] v);
    p_flags[FLAG_Z] = (v == 8'h00);
    p_flags[FLAG_N] = v[7];
  endfunction

  function automatic void compare_with(input logic [7:0] r, input logic [7:0] m);
    logic [7:0] d;
    d = r - m;
    p_flags[FLAG_C] = (r >= m);
    p_flags[FLAG_Z] = (r == m);
    p_flags[FLAG_N] = d[7];
  endfunction

  // Shift or rotate one byte; carry, zero and negative follow the result
  function automatic logic [7:0] shift_byte(input shift_t sh, input logic [7:0] v);
    logic [7:0] r;
    logic       cout;
    case (sh)
      SH_ASL: begin
        cout = v[7];
        r = {v[6:0], 1'b0};
      end
      SH_ROL: begin
        cout = v[7];
        r = {v[6:0], p_flags[FLAG_C]};
      end
      SH_LSR: begin
        cout = v[0];
        r = {1'b0, v[7:1]};
      end
      default: begin
        cout = v[0];
        r = {p_flags[FLAG_C], v[7:1]};
      end
    endcase
    p_flags[FLAG_C] = cout;
    set_zn(r);
    return r;
  endfunction

  // Execute one opcode on the predicted registers and build the result item
  function automatic out_item_t exec_predict(input in_item_t it);
    out_item_t  r;
    logic [2:0] aaa;
    logic [2:0] bbb;
    logic [1:0] cc;
    logic [7:0] m;
    logic [8:0] sum;
    logic       tested;
    logic       known;
    r = '0;
    aaa = it.kind[7:5];
    bbb = it.kind[4:2];
    cc = it.kind[1:0];
    m = it.operand;
    known = 1'b1;
    if (it.kind == OPC_HALT) begin
      r.outcome = OUTCOME_HALT;
    end else if (cc == CC_ALU) begin
      case (aaa)
        A_ORA: begin
          p_a = p_a | m;
          set_zn(p_a);
        end
        A_AND: begin
          p_a = p_a & m;
          set_zn(p_a);
        end
        A_EOR: begin
          p_a = p_a ^ m;
          set_zn(p_a);
        end
        A_ADC: begin
          // binary add whatever D holds
          sum = {1'b0, p_a} + {1'b0, m} + {8'd0, p_flags[FLAG_C]};
          p_flags[FLAG_C] = sum[8];
          p_flags[FLAG_V] = ~(p_a[7] ^ m[7]) & (p_a[7] ^ sum[7]);
          p_a = sum[7:0];
          set_zn(p_a);
        end
        A_LDA: begin
          p_a = m;
          set_zn(m);
        end
        A_CMP: compare_with(p_a, m);
        default: known = 1'b0;
      endcase
    end else if (cc == CC_RMW) begin
      case (aaa)
        R_ASL, R_ROL, R_LSR, R_ROR: begin
          if (bbb == B_IMPL) begin
            p_a = shift_byte(shift_t'(aaa[1:0]), p_a);
          end else if (bbb[0]) begin
            r.write_data = shift_byte(shift_t'(aaa[1:0]), m);
            r.mem_write = 1'b1;
          end else begin
            known = 1'b0;
          end
        end
        R_LDX: begin
          if (bbb[0] || bbb == B_IMM) begin
            p_x = m;
            set_zn(m);
          end else begin
            known = 1'b0;
          end
        end
        R_DEC: begin
          if (bbb[0]) begin
            r.write_data = m - 8'd1;
            r.mem_write = 1'b1;
            set_zn(r.write_data);
          end else if (bbb == B_IMPL) begin
            p_x = p_x - 8'd1;
            set_zn(p_x);
          end else begin
            known = 1'b0;
          end
        end
        R_INC: begin
          // the implied column of this row is NOP
          if (bbb[0]) begin
            r.write_data = m + 8'd1;
            r.mem_write = 1'b1;
            set_zn(r.write_data);
          end else if (bbb != B_IMPL) begin
            known = 1'b0;
          end
        end
        default: known = 1'b0;
      endcase
    end else if (cc == CC_CTL && bbb == B_REL) begin
      // row pairs test N, V, C, Z; the low row bit is the wanted value
      tested = aaa[2] ? (aaa[1] ? p_flags[FLAG_Z] : p_flags[FLAG_C])
                      : (aaa[1] ? p_flags[FLAG_V] : p_flags[FLAG_N]);
      r.branch_taken = (tested == aaa[0]);
    end else if (cc == CC_CTL) begin
      case (it.kind)
        OPC_PHP: begin
          r.write_data = p_flags;
          r.write_data[FLAG_B] = 1'b1;
          r.write_data[FLAG_U] = 1'b1;
          r.stack_push = 1'b1;
        end
        OPC_PHA: begin
          r.write_data = p_a;
          r.stack_push = 1'b1;
        end
        OPC_PLA: begin
          p_a = m;
          set_zn(m);
        end
        OPC_PLP: begin
          p_flags = m;
          p_flags[FLAG_B] = 1'b0;
          p_flags[FLAG_U] = 1'b1;
        end
        OPC_DEY: begin
          p_y = p_y - 8'd1;
          set_zn(p_y);
        end
        OPC_INY: begin
          p_y = p_y + 8'd1;
          set_zn(p_y);
        end
        OPC_INX: begin
          p_x = p_x + 8'd1;
          set_zn(p_x);
        end
        OPC_CLC: p_flags[FLAG_C] = 1'b0;
        OPC_CLI: p_flags[FLAG_I] = 1'b0;
        OPC_CLV: p_flags[FLAG_V] = 1'b0;
        OPC_CLD: p_flags[FLAG_D] = 1'b0;
        OPC_BIT_ZP, OPC_BIT_ABS: begin
          p_flags[FLAG_Z] = ((p_a & m) == 8'h00);
          p_flags[FLAG_N] = m[7];
          p_flags[FLAG_V] = m[6];
        end
        OPC_LDY_IMM, OPC_LDY_ZP, OPC_LDY_ABS, OPC_LDY_ZPX, OPC_LDY_ABSX: begin
          p_y = m;
          set_zn(m);
        end
        OPC_CPY_IMM, OPC_CPY_ZP, OPC_CPY_ABS: compare_with(p_y, m);
        OPC_CPX_IMM, OPC_CPX_ZP, OPC_CPX_ABS: compare_with(p_x, m);
        default: known = 1'b0;
      endcase
    end else begin
      known = 1'b0;
    end
    if (!known) r.outcome = OUTCOME_ILLEGAL;
    r.acc_out = p_a;
    r.x_out = p_x;
    r.y_out = p_y;
    r.flags_out = p_flags;
    return r;
  endfunction

  function automatic out_item_t plain_result(input outcome_t oc, input logic [7:0] acc,
                                             input logic [7:0] x, input logic [7:0] y,
                                             input logic [7:0] flags);
    out_item_t r;
    r = '0;
    r.outcome = oc;
    r.acc_out = acc;
    r.x_out = x;
    r.y_out = y;
    r.flags_out = flags;
    return r;
  endfunction

  function automatic void add_row(input logic [7:0] kind, input logic [7:0] operand);
    stim_row_t s;
    s.item.kind = kind;
    s.item.operand = operand;
    s.typed = 1'b0;
    s.want = '0;
    directed_rows.push_back(s);
  endfunction

  function automatic void add_typed(input logic [7:0] kind, input logic [7:0] operand,
                                    input out_item_t want);
    stim_row_t s;
    s.item.kind = kind;
    s.item.operand = operand;
    s.typed = 1'b1;
    s.want = want;
    directed_rows.push_back(s);
  endfunction

  // Wait count for one item: quiet stretches now and then, else 0..18
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm = calm - 1;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  task automatic report_mismatch(input string line);
    errors = errors + 1;
    if (errors <= MAX_PRINTED) $display("MISMATCH: %s", line);
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want, input in_item_t it);
    if (got !== want)
      report_mismatch($sformatf("kind %02h operand %02h: %s got %02h want %02h",
                                it.kind, it.operand, name, got, want));
  endtask

  // Offer one item at the falling edge, hold it until taken, then predict
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_want);
    int           gap;
    expectation_t e;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      op_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    op = it;
    op_valid = 1'b1;
    @(posedge clk);
    while (op_stall) @(posedge clk);
    e.item = it;
    e.want = exec_predict(it);
    if (typed) e.want = typed_want;
    pending_results.push_back(e);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Stall the result channel a random number of cycles per item
  initial begin : result_sink
    int hold;
    wait (rst == 1'b0);
    forever begin
      hold = draw_wait(sink_calm);
      if (hold > 0) begin
        res_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      res_stall = 1'b0;
      @(posedge clk);
      while (!res_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // Compare each taken result with the oldest prediction
  always @(posedge clk) begin : result_check
    expectation_t e;
    if (!rst && res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with no item pending, acc %02h flags %02h",
                                  res.acc_out, res.flags_out));
      end else begin
        e = pending_results.pop_front();
        check_field("write_data", res.write_data, e.want.write_data, e.item);
        check_field("mem_write", {7'd0, res.mem_write}, {7'd0, e.want.mem_write}, e.item);
        check_field("stack_push", {7'd0, res.stack_push}, {7'd0, e.want.stack_push},
                    e.item);
        check_field("branch_taken", {7'd0, res.branch_taken}, {7'd0, e.want.branch_taken},
                    e.item);
        check_field("outcome", {6'd0, res.outcome}, {6'd0, e.want.outcome}, e.item);
        check_field("acc_out", res.acc_out, e.want.acc_out, e.item);
        check_field("x_out", res.x_out, e.want.x_out, e.item);
        check_field("y_out", res.y_out, e.want.y_out, e.item);
        check_field("flags_out", res.flags_out, e.want.flags_out, e.item);
      end
    end
  end

  initial begin : stimulus
    in_item_t  it;
    out_item_t probe;
    int        k;
    int        n;

    // Collect every opcode that executes normally
    for (k = 0; k < 256; k++) begin
      reset_model();
      it.kind = k[7:0];
      it.operand = '0;
      probe = exec_predict(it);
      if (probe.outcome == OUTCOME_DONE) legal_kinds.push_back(it.kind);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    reset_model();

    // Directed: reset values, extremes, flag corners, push/pull, illegal and halt
    add_typed(OPC_LDA_IMM, 8'h00, plain_result(OUTCOME_DONE, 8'h00, 8'h00, 8'h00, 8'h26));
    add_typed(OPC_BRK, 8'hFF, plain_result(OUTCOME_ILLEGAL, 8'h00, 8'h00, 8'h00, 8'h26));
    add_typed(OPC_HALT, 8'h55, plain_result(OUTCOME_HALT, 8'h00, 8'h00, 8'h00, 8'h26));
    add_typed(OPC_LDA_IMM, 8'hFF, plain_result(OUTCOME_DONE, 8'hFF, 8'h00, 8'h00, 8'hA4));
    add_row(OPC_ADC_IMM, 8'h01);
    add_row(OPC_LDA_IMM, 8'h7F);
    add_row(OPC_ADC_IMM, 8'h00);
    add_row(OPC_PLP, 8'hFF);
    add_row(OPC_PHP, 8'h00);
    add_row(OPC_ADC_IMM, 8'hFF);
    add_row(OPC_ASL_A, 8'h00);
    add_row(OPC_ROR_ABS, 8'h01);
    add_row(OPC_ROL_A, 8'h00);
    add_row(OPC_LSR_A, 8'h00);
    add_row(OPC_INC_ZP, 8'hFF);
    add_row(OPC_DEC_ZP, 8'h00);
    add_row(OPC_LDX_IMM, 8'h80);
    add_row(OPC_DEX, 8'h00);
    add_row(OPC_INY, 8'h00);
    add_row(OPC_CPX_ABS, 8'h7F);
    add_row(OPC_CMP_IMM, 8'h80);
    add_row(OPC_BIT_ZP, 8'hC0);
    add_row(OPC_BVS, 8'h00);
    add_row(OPC_CLC, 8'h00);
    add_row(OPC_PHA, 8'h00);
    add_row(OPC_PLA, 8'h00);
    add_row(OPC_JSR, 8'h00);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

    // Random: mostly legal opcodes, some raw bytes, operands biased to corners
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        op_valid = 1'b0;
        wait_drained();
      end
      if ($urandom_range(0, 7) == 0)
        it.kind = 8'($urandom_range(0, 255));
      else
        it.kind = legal_kinds[$urandom_range(0, legal_kinds.size() - 1)];
      case ($urandom_range(0, 7))
        0: it.operand = 8'h00;
        1: it.operand = 8'hFF;
        2: it.operand = 8'h80;
        3: it.operand = 8'h7F;
        default: it.operand = 8'($urandom_range(0, 255));
      endcase
      send_item(it, 1'b0, '0);
    end

    // Drain and let any stray result show up
    op_valid = 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ cpu6502_execute_unit_top.f @@
design/cpu_exu_pkg.sv
design/cpu_exu_decode.sv
design/cpu_exu_alu.sv
design/cpu6502_execute_unit_top.sv
tb/cpu6502_execute_unit_top_tb.sv
